// ===== rtl/ifdc_pkg.sv =====
// shared constants, types and crc helper for the imu frame deframer
package ifdc_pkg;

    localparam int PAYLOAD_BYTES_DEF = 44;
    localparam int HEADER_LEN        = 5;
    localparam int CHECK_LEN         = 4;

    localparam int KIND_W  = 2;
    localparam int DATA_W  = 8;
    localparam int INDEX_W = 6;
    localparam int LIMIT_W = 5;

    localparam logic [DATA_W-1:0]  SYNC_BYTE = 8'hAA;
    localparam logic [31:0]        CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0]        CRC_INIT  = 32'h0000_0001;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 5'd20;
    localparam logic [LIMIT_W-1:0] LOSS_SAT     = 5'd30;
    localparam logic [LIMIT_W-1:0] LOSS_MAX     = 5'd31;
    localparam logic [LIMIT_W-1:0] LOSS_RESTART = 5'd1;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_BAD_HDR = 2'd1,
        KIND_CRC_ERR = 2'd2,
        KIND_LINK    = 2'd3
    } t_kind;

    typedef struct packed {
        logic               busy;
        logic [INDEX_W-1:0] rd_idx;
    } t_drain_st;

    function automatic logic [DATA_W-1:0] hdr_byte(input logic [2:0] pos);
        logic [DATA_W-1:0] v;
        unique case (pos)
            3'd1:    v = 8'h55;
            3'd2:    v = 8'h02;
            3'd3:    v = 8'h00;
            3'd4:    v = 8'h2C;
            3'd5:    v = 8'h00;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in,
                                             input logic [DATA_W-1:0] b);
        logic [31:0] c;
        c = c_in ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'h0);
        end
        return c;
    endfunction

endpackage

// ===== rtl/imu_frame_deframer_crc32.sv =====
// imu frame deframer: sync hunt, header check, crc-32 and payload playback
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | input     | i_in_valid/o_in_stall   | operation, rx_byte
//  out     | output    | o_out_valid/i_out_stall | kind, data_byte, byte_index, last, link_up
//  cfg     | input     | i_cfg_valid/o_cfg_ready | lost_limit
//
//  one input per cycle unless stalled; header, crc and loss update finish in that cycle
//  a verified frame plays back its payload from the memory, one byte per cycle unless
//  the output stalls, via the read and output registers; the single read port sets it
//  during playback, payload bytes are taken while their memory slot has been read out;
//  ticks and frame ends wait until playback is done
//  an error or status result appears the cycle after its transaction
//  synchronous active-low reset; no memory clearing pass, the payload memory is
//  always written by a frame before it is read
module imu_frame_deframer_crc32
    import ifdc_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_in_operation,
    input  logic [DATA_W-1:0]  i_in_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [KIND_W-1:0]  o_out_kind,
    output logic [DATA_W-1:0]  o_out_data_byte,
    output logic [INDEX_W-1:0] o_out_byte_index,
    output logic               o_out_last,
    output logic               o_out_link_up,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LIMIT_W-1:0] i_cfg_lost_limit
);

    localparam int IDX_W     = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int FRAME_LEN = 1 + HEADER_LEN + PAYLOAD_BYTES + CHECK_LEN;
    localparam int POS_W     = $clog2(FRAME_LEN + 1);
    localparam int PAY_BASE  = 1 + HEADER_LEN;
    localparam int CHK_BASE  = 1 + HEADER_LEN + PAYLOAD_BYTES;

    logic [LIMIT_W-1:0] r_limit;
    logic [POS_W-1:0]   r_pos,      n_pos;
    logic               r_in_frame, n_in_frame;
    logic               r_hdr_fail, n_hdr_fail;
    logic [31:0]        r_crc,      n_crc;
    logic [31:0]        r_check,    n_check;
    logic [LIMIT_W-1:0] r_loss,     n_loss;
    logic               r_online,   n_online;

    logic               r_out_valid;
    t_kind              r_out_kind;
    logic [DATA_W-1:0]  r_out_data;
    logic [INDEX_W-1:0] r_out_index;
    logic               r_out_last;
    logic               r_out_link;

    t_drain_st          w_st;
    logic               w_q_valid;
    logic [DATA_W-1:0]  w_q_data;
    logic [INDEX_W-1:0] w_q_idx;
    logic               w_q_last;

    logic               w_tick;
    logic               w_in_hdr;
    logic               w_in_pay;
    logic               w_final;
    logic [IDX_W-1:0]   w_pay_idx;
    logic [POS_W-1:0]   w_chk_off;
    logic [31:0]        w_check_full;
    logic               w_good;
    logic               w_has_result;
    logic               w_pay_wr;
    logic               w_wr_ok;
    logic               w_out_free;
    logic               w_acc;
    logic               w_wr_en;
    logic               w_start;
    logic               w_load_single;
    logic               w_move;
    logic [LIMIT_W-1:0] w_loss_inc;
    t_kind              w_single_kind;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_tick       = (i_in_operation == OP_TICK);
        w_in_hdr     = (r_pos <= POS_W'(HEADER_LEN));
        w_in_pay     = (r_pos < POS_W'(CHK_BASE));
        w_final      = r_in_frame && (r_pos == POS_W'(FRAME_LEN - 1));
        w_pay_idx    = IDX_W'(r_pos - POS_W'(PAY_BASE));
        w_chk_off    = r_pos - POS_W'(CHK_BASE);
        w_check_full = r_check | ({24'h0, i_in_rx_byte} << {w_chk_off[1:0], 3'b000});
        w_good       = !r_hdr_fail && (r_crc == w_check_full);
        w_has_result = w_tick || w_final;
        w_pay_wr     = !w_tick && r_in_frame && !w_in_hdr && w_in_pay;
        w_wr_ok      = !w_st.busy || (INDEX_W'(w_pay_idx) < w_st.rd_idx);
        w_out_free   = !r_out_valid || !i_out_stall;

        if (w_has_result) begin
            o_in_stall = w_st.busy || !w_out_free;
        end else begin
            o_in_stall = w_pay_wr && !w_wr_ok;
        end

        w_acc         = i_in_valid && !o_in_stall;
        w_wr_en       = w_acc && w_pay_wr;
        w_start       = w_acc && !w_tick && w_final && w_good;
        w_load_single = w_acc && w_has_result && !w_start;
        w_move        = w_q_valid && w_out_free;

        w_loss_inc = (r_loss != LOSS_MAX) ? (r_loss + LIMIT_W'(1)) : r_loss;

        n_pos      = r_pos;
        n_in_frame = r_in_frame;
        n_hdr_fail = r_hdr_fail;
        n_crc      = r_crc;
        n_check    = r_check;
        n_loss     = r_loss;
        n_online   = r_online;

        if (w_acc) begin
            if (w_tick) begin
                n_loss = w_loss_inc;
                if (w_loss_inc > r_limit) begin
                    n_loss   = LOSS_SAT;
                    n_online = 1'b0;
                end
            end else if (!r_in_frame) begin
                if (i_in_rx_byte == SYNC_BYTE) begin
                    n_in_frame = 1'b1;
                    n_pos      = POS_W'(1);
                    n_hdr_fail = 1'b0;
                    n_check    = '0;
                    n_crc      = crc_byte(CRC_INIT, i_in_rx_byte);
                end
            end else begin
                if (w_in_hdr) begin
                    if (i_in_rx_byte != hdr_byte(r_pos[2:0])) begin
                        n_hdr_fail = 1'b1;
                    end
                    n_crc = crc_byte(r_crc, i_in_rx_byte);
                end else if (w_in_pay) begin
                    n_crc = crc_byte(r_crc, i_in_rx_byte);
                end else begin
                    n_check = w_check_full;
                end
                n_pos = r_pos + POS_W'(1);
                if (w_final) begin
                    n_in_frame = 1'b0;
                    n_pos      = '0;
                    if (w_good) begin
                        n_online = 1'b1;
                        n_loss   = LOSS_RESTART;
                    end
                end
            end
        end

        if (w_tick) begin
            w_single_kind = KIND_LINK;
        end else if (r_hdr_fail) begin
            w_single_kind = KIND_BAD_HDR;
        end else begin
            w_single_kind = KIND_CRC_ERR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= LIMIT_RESET;
            r_pos      <= '0;
            r_in_frame <= 1'b0;
            r_hdr_fail <= 1'b0;
            r_crc      <= CRC_INIT;
            r_check    <= '0;
            r_loss     <= LOSS_RESTART;
            r_online   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_lost_limit;
            end
            r_pos      <= n_pos;
            r_in_frame <= n_in_frame;
            r_hdr_fail <= n_hdr_fail;
            r_crc      <= n_crc;
            r_check    <= n_check;
            r_loss     <= n_loss;
            r_online   <= n_online;
        end
    end

    // output register, fed by status results or by playback
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_single || w_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_single) begin
            r_out_kind  <= w_single_kind;
            r_out_data  <= '0;
            r_out_index <= '0;
            r_out_last  <= 1'b1;
            r_out_link  <= n_online;
        end else if (w_move) begin
            r_out_kind  <= KIND_PAYLOAD;
            r_out_data  <= w_q_data;
            r_out_index <= w_q_idx;
            r_out_last  <= w_q_last;
            r_out_link  <= 1'b1;
        end
    end

    ifdc_pbuf #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_pbuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_idx  (w_pay_idx),
        .i_wr_data (i_in_rx_byte),
        .i_start   (w_start),
        .i_take    (w_move),
        .o_st      (w_st),
        .o_q_valid (w_q_valid),
        .o_q_data  (w_q_data),
        .o_q_idx   (w_q_idx),
        .o_q_last  (w_q_last)
    );

    assign o_out_valid      = r_out_valid;
    assign o_out_kind       = r_out_kind;
    assign o_out_data_byte  = r_out_data;
    assign o_out_byte_index = r_out_index;
    assign o_out_last       = r_out_last;
    assign o_out_link_up    = r_out_link;

    a_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_load_single && w_move))
        else $error("status result and playback byte loaded together");

    a_wr_behind_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_en && w_st.busy) |-> (INDEX_W'(w_pay_idx) < w_st.rd_idx))
        else $error("payload write overtakes playback read");

    a_loss_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loss != '0)
        else $error("loss counter reached zero");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_PAYLOAD && r_out_last)
            |-> (r_out_index == INDEX_W'(PAYLOAD_BYTES - 1)))
        else $error("last payload byte at wrong index");

    a_start_online: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_online && r_loss == LOSS_RESTART))
        else $error("verified frame did not bring link up");

endmodule

// ===== rtl/ifdc_pbuf.sv =====
// payload memory with read sequencer that plays back a verified frame
module ifdc_pbuf
    import ifdc_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [((PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1)-1:0] i_wr_idx,
    input  logic [DATA_W-1:0]  i_wr_data,
    input  logic               i_start,
    input  logic               i_take,
    output t_drain_st          o_st,
    output logic               o_q_valid,
    output logic [DATA_W-1:0]  o_q_data,
    output logic [INDEX_W-1:0] o_q_idx,
    output logic               o_q_last
);

    localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);

    logic [DATA_W-1:0] mem [PAYLOAD_BYTES];

    logic              r_active;
    logic [CNT_W-1:0]  r_rd_idx;
    logic              r_pend;
    logic [DATA_W-1:0] r_q_data;
    logic [IDX_W-1:0]  r_q_idx;
    logic              r_q_last;
    logic              w_rd_en;
    logic [IDX_W-1:0]  w_addr;

    assign w_addr  = r_rd_idx[IDX_W-1:0];
    assign w_rd_en = r_active && (!r_pend || i_take);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_q_data <= mem[w_addr];
            r_q_idx  <= w_addr;
            r_q_last <= (r_rd_idx == CNT_W'(PAYLOAD_BYTES - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_rd_idx <= '0;
            r_pend   <= 1'b0;
        end else begin
            if (i_start) begin
                r_active <= 1'b1;
                r_rd_idx <= '0;
            end else if (w_rd_en) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
                if (r_rd_idx == CNT_W'(PAYLOAD_BYTES - 1)) begin
                    r_active <= 1'b0;
                end
            end
            r_pend <= w_rd_en || (r_pend && !i_take);
        end
    end

    assign o_st.busy   = r_active || r_pend;
    assign o_st.rd_idx = INDEX_W'(r_rd_idx);
    assign o_q_valid   = r_pend;
    assign o_q_data    = r_q_data;
    assign o_q_idx     = INDEX_W'(r_q_idx);
    assign o_q_last    = r_q_last;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !(r_active || r_pend))
        else $error("playback started while busy");

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> r_pend)
        else $error("read data taken while none pending");

    a_hold_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !i_take) |=> (r_pend && $stable(r_q_data)))
        else $error("pending read data changed before it was taken");

endmodule
